// ----- src/scds_pkg.sv -----
package scds_pkg;

	// Field widths fixed by the item formats
	localparam int ROW_W   = 12;
	localparam int VAL_W   = 32;
	localparam int SLOT_W  = 16;
	localparam int START_W = 17;

	localparam logic [VAL_W-1:0] SUM_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] SUM_MIN = 32'h8000_0000;

	// One input beat
	typedef struct packed {
		logic [ROW_W-1:0]        row_index;
		logic signed [VAL_W-1:0] entry_value;
		logic                    has_entry;
		logic                    end_of_column;
		logic                    first_of_matrix;
	} in_item_t;

	// One result beat
	typedef struct packed {
		logic [SLOT_W-1:0]       slot;
		logic [ROW_W-1:0]        out_row;
		logic signed [VAL_W-1:0] sum_value;
		logic [START_W-1:0]      column_start;
		logic                    entry_present;
		logic                    saturated;
		logic                    dropped;
		logic                    last_of_column;
	} out_item_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic look;
		logic update;
		logic drain_init;
		logic drain_read;
		logic emit_empty;
		logic emit_entry;
		logic finish;
	} ctl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clearing;
		logic in_go;
		logic in_eoc;
		logic item_eoc;
		logic count_zero;
		logic drain_last;
		logic out_free;
	} dp_status_t;

endpackage

// ----- src/scds_ctrl.sv -----
module scds_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  scds_pkg::dp_status_t status,
	output scds_pkg::ctl_cmd_t   cmd
);
	import scds_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOOK  = 3'd1;
	localparam logic [2:0] ST_UPD   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DRD   = 3'd4;
	localparam logic [2:0] ST_DOUT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic       accept;

	// Take input only in the idle state and once the marker table is cleared
	assign in_ready = (state_q == ST_IDLE) && !status.clearing;
	assign accept   = in_valid && in_ready;

	// Decode state into datapath commands and pick the next state
	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.accept = 1'b1;
					if (status.in_go)
						state_next = ST_LOOK;
					else if (status.in_eoc)
						state_next = ST_DRAIN;
				end
			end
			ST_LOOK: begin
				cmd.look   = 1'b1;
				state_next = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_next = status.item_eoc ? ST_DRAIN : ST_IDLE;
			end
			ST_DRAIN: begin
				if (status.count_zero) begin
					if (status.out_free) begin
						cmd.emit_empty = 1'b1;
						cmd.finish     = 1'b1;
						state_next     = ST_IDLE;
					end
				end else begin
					cmd.drain_init = 1'b1;
					state_next     = ST_DRD;
				end
			end
			ST_DRD: begin
				cmd.drain_read = 1'b1;
				state_next     = ST_DOUT;
			end
			ST_DOUT: begin
				if (status.out_free) begin
					cmd.emit_entry = 1'b1;
					if (status.drain_last) begin
						cmd.finish = 1'b1;
						state_next = ST_IDLE;
					end else begin
						state_next = ST_DRD;
					end
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// At most one datapath operation per cycle
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.look, cmd.update, cmd.drain_init,
			cmd.drain_read, cmd.emit_empty, cmd.emit_entry}))
		else $error("scds_ctrl: overlapping datapath commands");

	// Finish only comes with the beat that closes the column
	a_finish_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (cmd.emit_empty || cmd.emit_entry))
		else $error("scds_ctrl: column finished without a result");

endmodule

// ----- src/scds_dp.sv -----
module scds_dp #(
	parameter int MAX_ROWS           = 4096,
	parameter int MAX_SLOTS          = 65536,
	parameter int MAX_COLUMN_ENTRIES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scds_pkg::in_item_t   in_data,
	input  scds_pkg::ctl_cmd_t   cmd,
	output scds_pkg::dp_status_t status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output scds_pkg::out_item_t  out_data
);
	import scds_pkg::*;

	localparam int MarkerDepth = (MAX_ROWS < (1 << ROW_W)) ? MAX_ROWS : (1 << ROW_W);
	localparam int AW = $clog2(MarkerDepth);
	localparam int SW = $clog2(MAX_SLOTS + 1);
	localparam int CW = $clog2(MAX_COLUMN_ENTRIES + 1);
	localparam int IW = $clog2(MAX_COLUMN_ENTRIES);
	localparam int DW = (SW > CW) ? SW : CW;
	localparam logic [20:0]   RowLimit  = 21'(MAX_ROWS);
	localparam logic [SW-1:0] SlotLimit = SW'(MAX_SLOTS);
	localparam logic [CW-1:0] CountMax  = CW'(MAX_COLUMN_ENTRIES);
	localparam logic [AW-1:0] ClearLast = AW'(MarkerDepth - 1);

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [VAL_W-1:0] sum;
		logic             sat;
	} buf_entry_t;

	// Marker table: last slot given to each row
	logic [SW-1:0] marker_mem [MarkerDepth];
	// Column buffer: rows, running sums and saturation flags of the open column
	buf_entry_t    col_mem [MAX_COLUMN_ENTRIES];

	logic [SW-1:0]    slot_q;
	logic [SW-1:0]    ccs_q;
	logic [CW-1:0]    count_q;
	logic             dropped_q;
	logic [IW-1:0]    idx_q;
	logic             out_valid_q;
	out_item_t        out_data_q;
	logic [AW-1:0]    clr_q;
	logic             clearing_q;

	logic [ROW_W-1:0] row_q;
	logic [VAL_W-1:0] val_q;
	logic             eoc_q;
	logic [SW-1:0]    mk_q;
	logic             cand_q;
	logic [IW-1:0]    k_q;
	buf_entry_t       buf_rd_q;

	logic             in_row_ok;
	logic [SW-1:0]    diff;
	logic             in_col;
	logic [IW-1:0]    rd_addr;
	logic             hit;
	logic             no_room;
	logic [VAL_W:0]   sum_ext;
	logic             ovf;
	logic [VAL_W-1:0] sat_sum;
	logic             out_free;

	assign in_row_ok = ({9'd0, in_data.row_index} < RowLimit);

	// Where the row's marker points, relative to the open column
	assign diff   = mk_q - ccs_q;
	assign in_col = (mk_q >= ccs_q) && (DW'(diff) < DW'(count_q));

	assign rd_addr = cmd.look ? diff[IW-1:0] : idx_q;

	// A marker counts only if the buffer entry it points at holds the same row
	assign hit     = cand_q && (buf_rd_q.row == row_q);
	assign no_room = (count_q == CountMax) || (slot_q == SlotLimit);

	// Saturating add of the new value into the running sum
	assign sum_ext = {buf_rd_q.sum[VAL_W-1], buf_rd_q.sum} + {val_q[VAL_W-1], val_q};
	assign ovf     = (sum_ext[VAL_W] != sum_ext[VAL_W-1]);
	assign sat_sum = ovf ? (sum_ext[VAL_W] ? SUM_MIN : SUM_MAX) : sum_ext[VAL_W-1:0];

	assign out_free = !out_valid_q || out_ready;

	assign status.clearing   = clearing_q;
	assign status.in_go      = in_data.has_entry && in_row_ok;
	assign status.in_eoc     = in_data.end_of_column;
	assign status.item_eoc   = eoc_q;
	assign status.count_zero = (count_q == '0);
	assign status.drain_last = ((CW'(idx_q) + CW'(1)) == count_q);
	assign status.out_free   = out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Walk the marker table once after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == ClearLast)
				clearing_q <= 1'b0;
		end
	end

	// Marker table port: clear after reset, read on accept, write on a new entry
	always_ff @(posedge clk) begin
		if (cmd.accept)
			mk_q <= marker_mem[in_data.row_index[AW-1:0]];
		if (clearing_q)
			marker_mem[clr_q] <= '0;
		else if (cmd.update && !hit && !no_room)
			marker_mem[row_q[AW-1:0]] <= slot_q;
	end

	// Column buffer port: registered read, write on hit or new entry
	always_ff @(posedge clk) begin
		if (cmd.look || cmd.drain_read)
			buf_rd_q <= col_mem[rd_addr];
		if (cmd.update) begin
			if (hit)
				col_mem[k_q] <= '{row: row_q, sum: sat_sum, sat: buf_rd_q.sat | ovf};
			else if (!no_room)
				col_mem[count_q[IW-1:0]] <= '{row: row_q, sum: val_q, sat: 1'b0};
		end
	end

	// Hold the item and the lookup result
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			row_q <= in_data.row_index;
			val_q <= in_data.entry_value;
			eoc_q <= in_data.end_of_column;
		end
		if (cmd.look) begin
			cand_q <= in_col;
			k_q    <= diff[IW-1:0];
		end
	end

	// Slot counter, column start, fill count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			ccs_q     <= '0;
			count_q   <= '0;
			dropped_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (cmd.accept) begin
				if (in_data.first_of_matrix) begin
					slot_q    <= '0;
					ccs_q     <= '0;
					count_q   <= '0;
					dropped_q <= 1'b0;
				end
				if (in_data.has_entry && !in_row_ok)
					dropped_q <= 1'b1;
			end
			if (cmd.update && !hit) begin
				if (no_room) begin
					dropped_q <= 1'b1;
				end else begin
					slot_q  <= slot_q + SW'(1);
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.drain_init)
				idx_q <= '0;
			else if (cmd.emit_entry)
				idx_q <= idx_q + IW'(1);
			if (cmd.finish) begin
				ccs_q     <= slot_q;
				count_q   <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

	// Output register: load on emit, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_empty || cmd.emit_entry) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_empty) begin
			out_data_q <= '{slot: '0, out_row: '0, sum_value: '0,
				column_start: START_W'(ccs_q), entry_present: 1'b0,
				saturated: 1'b0, dropped: dropped_q, last_of_column: 1'b1};
		end else if (cmd.emit_entry) begin
			out_data_q <= '{slot: SLOT_W'(ccs_q + SW'(idx_q)), out_row: buf_rd_q.row,
				sum_value: buf_rd_q.sum, column_start: START_W'(ccs_q),
				entry_present: 1'b1, saturated: buf_rd_q.sat, dropped: dropped_q,
				last_of_column: status.drain_last};
		end
	end

	// The open column never holds more than the buffer depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountMax)
		else $error("scds_dp: column count beyond buffer depth");

	// Slots given out since the column opened match the fill count
	a_slot_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ccs_q <= slot_q) && (DW'(slot_q - ccs_q) == DW'(count_q)))
		else $error("scds_dp: slot counter and column count disagree");

	// An emit never overwrites a result that has not been taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_empty || cmd.emit_entry) |-> out_free)
		else $error("scds_dp: result register overrun");

endmodule

// ----- src/sparse_column_duplicate_sum.sv -----
// Sums duplicate entries of a compressed sparse matrix one column at a time.
// Each entry passes through a marker table read, a column buffer read at
// the slot the marker names, and the update (saturating add or a new slot).
// An item without an entry skips the lookup. Closing a column passes through
// a drain step, then per result a buffer read and then a load of the output
// register, held while the output is stalled; an empty column gives its single
// result from the drain step itself. After reset the marker table is cleared
// one entry per cycle (MAX_ROWS entries, at most 4096) before the first item is
// taken. first_of_matrix needs no clearing pass: a marker is trusted only when
// it falls inside the open column and the buffer entry there holds the same
// row, so stale markers are harmless. Input is taken only while no entry or
// drain is in progress; a result waits in the output register while the next
// item is accepted.
module sparse_column_duplicate_sum #(
	parameter int MAX_ROWS           = 4096,
	parameter int MAX_SLOTS          = 65536,
	parameter int MAX_COLUMN_ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  scds_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output scds_pkg::out_item_t out_data
);
	import scds_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	scds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	scds_dp #(
		.MAX_ROWS           (MAX_ROWS),
		.MAX_SLOTS          (MAX_SLOTS),
		.MAX_COLUMN_ENTRIES (MAX_COLUMN_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- verif/tb_sparse_column_duplicate_sum.sv -----
`timescale 1ns / 100ps

module tb_sparse_column_duplicate_sum;
	import scds_pkg::*;

	localparam int     ROW_COUNT   = 4096;
	localparam int     SLOT_LIMIT  = 65536;
	localparam int     COL_DEPTH   = 64;
	localparam int     IDLE_PCT    = 23;
	localparam int     DRAIN_WAIT  = 200;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam longint SUM_HI      = 64'sd2147483647;
	localparam longint SUM_LO      = -64'sd2147483648;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	sparse_column_duplicate_sum u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// Model of the block: row markers, slot counter and the open column
	logic [16:0]        row_slot [ROW_COUNT];
	bit                 row_seen [ROW_COUNT];
	int unsigned        next_slot = 0;
	int unsigned        col_base = 0;
	logic [ROW_W-1:0]   col_row [COL_DEPTH];
	logic signed [31:0] col_sum [COL_DEPTH];
	bit                 col_clip [COL_DEPTH];
	int unsigned        col_fill = 0;
	bit                 col_lost = 1'b0;
	out_item_t          expected_sums [$];

	in_item_t    pending_items [$];
	int          item_total = 0;
	int          taken_count = 0;
	int          sent_count = 0;
	int          result_count = 0;
	int          fault_count = 0;
	longint      cycle_count = 0;
	logic        in_taken = 1'b0;

	function automatic string show_result(out_item_t r);
		return $sformatf("slot %0d row %0d sum %h start %0d present %b sat %b drop %b last %b",
			r.slot, r.out_row, r.sum_value, r.column_start, r.entry_present,
			r.saturated, r.dropped, r.last_of_column);
	endfunction

	// Fold one accepted beat into the model and queue the column's results
	task automatic sum_duplicates(input in_item_t it);
		int unsigned k;
		longint      s;
		bit          merged;
		out_item_t   r;

		merged = 1'b0;
		if (it.first_of_matrix) begin
			row_seen  = '{default: 1'b0};
			next_slot = 0;
			col_base  = 0;
			col_fill  = 0;
			col_lost  = 1'b0;
		end

		// Rows are 12 bits wide, so every row index is in range here
		if (it.has_entry) begin
			if (row_seen[it.row_index] && row_slot[it.row_index] >= col_base) begin
				k = row_slot[it.row_index] - col_base;
				if (k < col_fill && k < COL_DEPTH) begin
					s = longint'(col_sum[k]) + longint'(it.entry_value);
					if (s > SUM_HI) begin
						s = SUM_HI;
						col_clip[k] = 1'b1;
					end
					if (s < SUM_LO) begin
						s = SUM_LO;
						col_clip[k] = 1'b1;
					end
					col_sum[k] = 32'(s);
					merged = 1'b1;
				end
			end
			if (!merged) begin
				if (col_fill >= COL_DEPTH || next_slot >= SLOT_LIMIT) begin
					col_lost = 1'b1;
				end else begin
					row_seen[it.row_index] = 1'b1;
					row_slot[it.row_index] = 17'(next_slot);
					col_row[col_fill]  = it.row_index;
					col_sum[col_fill]  = it.entry_value;
					col_clip[col_fill] = 1'b0;
					col_fill++;
					next_slot++;
				end
			end
		end

		// Close the column: one result per slot, or a single empty marker
		if (it.end_of_column) begin
			if (col_fill == 0) begin
				r = '0;
				r.column_start   = START_W'(col_base);
				r.dropped        = col_lost;
				r.last_of_column = 1'b1;
				expected_sums.push_back(r);
			end else begin
				for (k = 0; k < col_fill; k++) begin
					r = '0;
					r.slot           = SLOT_W'(col_base + k);
					r.out_row        = col_row[k];
					r.sum_value      = col_sum[k];
					r.column_start   = START_W'(col_base);
					r.entry_present  = 1'b1;
					r.saturated      = col_clip[k];
					r.dropped        = col_lost;
					r.last_of_column = (k + 1 == col_fill);
					expected_sums.push_back(r);
				end
			end
			col_base = next_slot;
			col_fill = 0;
			col_lost = 1'b0;
		end
	endtask

	task automatic push_item(input logic [ROW_W-1:0] row, input logic [VAL_W-1:0] val,
			input bit has, input bit eoc, input bit fom);
		in_item_t it;

		it.row_index       = row;
		it.entry_value     = val;
		it.has_entry       = has;
		it.end_of_column   = eoc;
		it.first_of_matrix = fom;
		pending_items.push_back(it);
	endtask

	// Lean toward large same-sign values so sums clip often
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h4000_0000 + $urandom_range(32'h3FFF_FFFF);
			3: return 32'hC000_0000 - $urandom_range(32'h3FFF_FFFF);
			4: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		forever #6 clk = ~clk;
	end

	// Driver: present beats on the falling edge, hold until taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!(in_valid && !in_taken)) begin
				if (pending_items.size() != 0 &&
						((sent_count >= 80 && sent_count < 150) ||
						$urandom_range(99) >= IDLE_PCT)) begin
					in_data    <= pending_items.pop_front();
					in_valid   <= 1'b1;
					sent_count <= sent_count + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= (result_count >= 60 && result_count < 140) ||
				$urandom_range(99) >= IDLE_PCT;
		end
	end

	// Monitor: check result beats first, then predict from the input beat
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		in_taken    <= in_valid && in_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				result_count <= result_count + 1;
				if (expected_sums.size() == 0) begin
					if (fault_count < 10)
						$display("unexpected result: %s", show_result(out_data));
					fault_count++;
				end else begin
					if (out_data.slot !== expected_sums[0].slot ||
							out_data.out_row !== expected_sums[0].out_row ||
							out_data.sum_value !== expected_sums[0].sum_value ||
							out_data.column_start !== expected_sums[0].column_start ||
							out_data.entry_present !== expected_sums[0].entry_present ||
							out_data.saturated !== expected_sums[0].saturated ||
							out_data.dropped !== expected_sums[0].dropped ||
							out_data.last_of_column !== expected_sums[0].last_of_column) begin
						if (fault_count < 10) begin
							$display("mismatch at cycle %0d", cycle_count);
							$display("  expected %s", show_result(expected_sums[0]));
							$display("  actual   %s", show_result(out_data));
						end
						fault_count++;
					end
					void'(expected_sums.pop_front());
				end
			end
			if (in_valid && in_ready) begin
				sum_duplicates(in_data);
				taken_count <= taken_count + 1;
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int               n;
		int               i;
		int               pick;
		int               spread;
		int               random_items;
		bit               split_close;
		logic [ROW_W-1:0] row_base;

		// Directed: extremes, clipping both ways, empty and abandoned columns
		push_item(12'h000, 32'h7FFF_FFFF, 1, 1, 1);
		push_item(12'hFFF, 32'h7FFF_FFFF, 1, 0, 0);
		push_item(12'hFFF, 32'h7FFF_FFFF, 1, 0, 0);
		push_item(12'h000, 32'h8000_0000, 1, 0, 0);
		push_item(12'h000, 32'h8000_0000, 1, 0, 0);
		push_item(12'hFFF, 32'hFFFF_FFFB, 1, 0, 0);
		push_item(12'h005, 32'hFFFF_FFFF, 1, 0, 0);
		push_item(12'h005, 32'h0000_0001, 1, 1, 0);
		push_item(12'h000, 32'h0000_0000, 0, 1, 0);
		push_item(12'hFFF, 32'h8000_0000, 0, 0, 0);
		push_item(12'h003, 32'h0001_0000, 1, 0, 0);
		push_item(12'h003, 32'h0002_0000, 1, 1, 0);
		push_item(12'h003, 32'h0000_0001, 1, 1, 0);
		push_item(12'h007, 32'h0000_007B, 1, 0, 0);
		push_item(12'h000, 32'h0000_0000, 0, 0, 1);
		push_item(12'h007, 32'h0000_0005, 1, 1, 0);
		push_item(12'hFFF, 32'h8000_0000, 1, 1, 1);
		push_item(12'h000, 32'h0000_0000, 0, 1, 1);
		push_item(12'hAAA, 32'h5555_5555, 1, 0, 0);
		push_item(12'h555, 32'hAAAA_AAAA, 1, 1, 0);

		// Random columns over small row pools, with noise and broken columns
		random_items = 0;
		while (random_items < 80) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				push_item(ROW_W'($urandom), $urandom, 0, 0, $urandom_range(3) == 0);
			end else if (pick < 16) begin
				push_item(ROW_W'($urandom), $urandom, 0, 1, $urandom_range(7) == 0);
				random_items++;
			end else begin
				n           = $urandom_range(12, 1);
				row_base    = ROW_W'($urandom);
				spread      = $urandom_range(15, 1);
				split_close = $urandom_range(3) == 0;
				for (i = 0; i < n; i++) begin
					push_item(ROW_W'(row_base + $urandom_range(spread)), pick_value(), 1,
						!split_close && i == n - 1,
						(i == 0 && $urandom_range(9) == 0) || $urandom_range(39) == 0);
					random_items++;
				end
				if (split_close) begin
					push_item(ROW_W'($urandom), $urandom, 0, 1, 0);
					random_items++;
				end
			end
		end

		// Column buffer overflow: one distinct row more than the buffer holds
		row_base = ROW_W'($urandom);
		for (i = 0; i <= COL_DEPTH; i++)
			push_item(ROW_W'(row_base + i), $urandom, 1, i == COL_DEPTH, 0);

		// Close out with new rows, then restart the matrix
		push_item(12'h123, 32'h0000_0001, 1, 0, 0);
		push_item(12'h456, 32'h0000_0002, 1, 1, 0);
		push_item(12'h000, 32'h0000_0000, 0, 1, 0);
		push_item(12'h009, 32'h0003_0000, 1, 1, 1);
		item_total = pending_items.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: every beat taken, every result seen, then a quiet spell
		while (taken_count != item_total || expected_sums.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (fault_count == 0 && expected_sums.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- files.f -----
src/scds_pkg.sv
src/scds_ctrl.sv
src/scds_dp.sv
src/sparse_column_duplicate_sum.sv
verif/tb_sparse_column_duplicate_sum.sv
